// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the translation table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/tlbrr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbrr_pkg
// Field widths, operation and result codes, and entry types of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlbrr_pkg;

    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int PID_W       = 16;
    localparam int COUNT_W     = 21;
    localparam int SLOT_W      = 6;
    localparam int HITS_W      = 7;
    localparam int CNT_W       = 7;
    localparam int MAX_RESULTS = 64;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_INVAL  = 2'd1,
        FUNC_SWITCH = 2'd2
    } t_func;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_FREE     = 3'd0,
        KIND_REPLACED = 3'd1,
        KIND_CLEARED  = 3'd2,
        KIND_EVICT    = 3'd3,
        KIND_EMPTY    = 3'd4,
        KIND_SAME     = 3'd5
    } t_kind;

    // Configuration register indexes.
    localparam logic CFG_TEXT_BASE  = 1'b0;
    localparam logic CFG_TEXT_COUNT = 1'b1;

    // One stored translation.
    typedef struct packed {
        logic               writable;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
    } t_entry;

    // One result item.
    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [HITS_W-1:0] hits;
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/tlbrr_ram.sv =====
// ----------------------------------------------------------------------------
// tlbrr_ram
// Single-clock entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbrr_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire tlbrr_pkg::t_entry i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output tlbrr_pkg::t_entry      o_rdata
);

    tlbrr_pkg::t_entry r_mem [DEPTH];
    tlbrr_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tlbrr_free_find.sv =====
// ----------------------------------------------------------------------------
// tlbrr_free_find
// Two-stage registered search for the lowest slot whose valid bit is clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlbrr_free_find #(
    parameter int ENTRIES = 64,
    parameter int IW      = 6
) (
    input  wire logic               i_clk,
    input  wire logic [ENTRIES-1:0] i_valid,
    output logic                    o_found,
    output logic [IW-1:0]           o_idx
);

    localparam int GS  = 16;
    localparam int GBW = 4;
    localparam int G   = (ENTRIES + GS - 1) / GS;
    localparam int GW  = (G > 1) ? $clog2(G) : 1;

    logic [G*GS-1:0]  vpad;
    logic [G-1:0]     n_gfree;
    logic [GBW-1:0]   n_gidx [G];
    logic [G-1:0]     r_gfree;
    logic [GBW-1:0]   r_gidx [G];
    logic             n_found;
    logic [GW+GBW-1:0] n_idx;
    logic             r_found;
    logic [IW-1:0]    r_idx;

    // Slots past the table read as occupied.
    always_comb begin
        vpad = '1;
        vpad[ENTRIES-1:0] = i_valid;
    end

    // First stage: lowest free bit inside each group of sixteen.
    always_comb begin
        for (int g = 0; g < G; g++) begin
            n_gfree[g] = ~&vpad[g*GS +: GS];
            n_gidx[g]  = '0;
            for (int b = GS - 1; b >= 0; b--) begin
                if (!vpad[g*GS + b]) begin
                    n_gidx[g] = GBW'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gfree <= n_gfree;
        for (int g = 0; g < G; g++) begin
            r_gidx[g] <= n_gidx[g];
        end
    end

    // Second stage: lowest group that has a free slot.
    always_comb begin
        n_found = |r_gfree;
        n_idx   = '0;
        for (int g = G - 1; g >= 0; g--) begin
            if (r_gfree[g]) begin
                n_idx = {GW'(g), r_gidx[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_idx   <= IW'(n_idx);
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

`default_nettype wire

// ===== rtl/tlb_refill_round_robin_core.sv =====
// ----------------------------------------------------------------------------
// tlb_refill_round_robin_core
// Translation table with lowest-free insert, round-robin replacement,
// invalidate by frame and process-switch flush with eviction notices.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Contents
//  request   in         i_valid / o_ready          func, page, frame, pid
//  result    out        o_valid / i_ready          kind, slot, hits, page, pid, last
//  config    in         i_cfg_valid / o_cfg_ready  register index, data
//
//  An insert holds off the next request until its result is pushed; its
//  free-slot search is a two-stage registered tree over the valid bits.
//  Invalidate and process switch walk the entry memory one entry per cycle
//  through its read port, pausing while a result waits on the output.
//  Reset clears the valid bits at once; no sweep of the memory follows.
//  A full output register stalls only the step that pushes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlb_refill_round_robin_core #(
    parameter int TLB_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [19:0] i_page,
    input  wire logic [19:0] i_frame,
    input  wire logic [15:0] i_pid,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_kind,
    output logic [5:0]       o_slot,
    output logic [6:0]       o_hits,
    output logic [19:0]      o_evicted_page,
    output logic [15:0]      o_evicted_pid,
    output logic             o_last,
    // Configuration channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [20:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int IW      = $clog2(TLB_ENTRIES);
    localparam int AW1     = IW + 1;
    localparam int PAGE_W  = tlbrr_pkg::PAGE_W;
    localparam int FRAME_W = tlbrr_pkg::FRAME_W;
    localparam int PID_W   = tlbrr_pkg::PID_W;
    localparam int COUNT_W = tlbrr_pkg::COUNT_W;
    localparam int SLOT_W  = tlbrr_pkg::SLOT_W;
    localparam int HITS_W  = tlbrr_pkg::HITS_W;
    localparam int CNT_W   = tlbrr_pkg::CNT_W;
    localparam int MAXRES  = tlbrr_pkg::MAX_RESULTS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_FIND2 = 6'b000100,
        S_INS   = 6'b001000,
        S_SCAN  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // Control state.
    t_state               r_state;
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [IW-1:0]        r_victim;
    logic [PID_W-1:0]     r_last_pid;
    logic [PAGE_W-1:0]    r_text_base;
    logic [COUNT_W-1:0]   r_text_count;
    logic                 r_out_valid;
    logic [AW1-1:0]       r_rd_addr;
    logic                 r_chk_valid;
    logic                 r_pend_valid;
    logic [CNT_W-1:0]     r_cnt;
    logic [HITS_W-1:0]    r_hits;

    // Request and result payload.
    tlbrr_pkg::t_func     r_op;
    logic [PAGE_W-1:0]    r_page;
    logic [FRAME_W-1:0]   r_frame;
    logic [PID_W-1:0]     r_pid;
    logic [IW-1:0]        r_chk_idx;
    logic [IW-1:0]        r_pend_slot;
    logic [PAGE_W-1:0]    r_pend_page;
    tlbrr_pkg::t_result   r_res;
    tlbrr_pkg::t_result   r_out;

    // Memory and search connections.
    tlbrr_pkg::t_entry    rd_data;
    tlbrr_pkg::t_entry    wr_data;
    logic                 ram_we;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic                 find_found;
    logic [IW-1:0]        find_idx;

    // Step controls.
    logic                 accept;
    logic                 out_free;
    logic                 chk_hit;
    logic                 push_pend;
    logic                 scan_go;
    logic                 scan_proc;
    logic                 issue_more;
    logic                 scan_done;
    logic                 fin_push;
    logic                 out_push;
    logic [IW-1:0]        ins_slot;
    logic [PAGE_W-1:0]    text_off;
    logic                 text_ro;

    tlbrr_ram #(
        .DEPTH (TLB_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ins_slot),
        .i_wdata (wr_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    tlbrr_free_find #(
        .ENTRIES (TLB_ENTRIES),
        .IW      (IW)
    ) u_find (
        .i_clk   (i_clk),
        .i_valid (r_valid),
        .o_found (find_found),
        .o_idx   (find_idx)
    );

    // Handshake and scan step decisions.
    always_comb begin
        accept     = i_valid && (r_state == S_IDLE);
        out_free   = !r_out_valid || i_ready;
        chk_hit    = r_chk_valid && r_valid[r_chk_idx] &&
                     ((r_op == tlbrr_pkg::FUNC_INVAL) ? (rd_data.frame == r_frame)
                                                      : (r_cnt < CNT_W'(MAXRES)));
        push_pend  = (r_state == S_SCAN) && (r_op == tlbrr_pkg::FUNC_SWITCH) &&
                     chk_hit && r_pend_valid;
        scan_go    = (r_state == S_SCAN) && !(push_pend && !out_free);
        scan_proc  = scan_go && r_chk_valid;
        issue_more = r_rd_addr < AW1'(TLB_ENTRIES);
        scan_done  = scan_go && !issue_more && !r_chk_valid;
        fin_push   = (r_state == S_FIN) && out_free;
        out_push   = (scan_go && push_pend) || fin_push;
    end

    // Memory read port: victim entry on insert, walk address during a scan.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_rd_addr[IW-1:0];
        if (accept && (i_func == tlbrr_pkg::FUNC_INSERT)) begin
            ram_re    = 1'b1;
            ram_raddr = r_victim;
        end else if (scan_go && issue_more) begin
            ram_re = 1'b1;
        end
    end

    // Insert write: lowest free slot, else the victim; text pages are read-only.
    always_comb begin
        ins_slot  = find_found ? find_idx : r_victim;
        text_off  = r_page - r_text_base;
        text_ro   = (r_page >= r_text_base) &&
                    ({1'b0, text_off} < r_text_count);
        ram_we    = (r_state == S_INS);
        wr_data   = '{writable: !text_ro, frame: r_frame, page: r_page};
    end

    // Output register valid: set on a push, cleared when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_push) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Control registers and the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_victim     <= '0;
            r_last_pid   <= '0;
            r_text_base  <= '0;
            r_text_count <= '0;
            r_rd_addr    <= '0;
            r_chk_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
            r_hits       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tlbrr_pkg::CFG_TEXT_BASE:  r_text_base  <= i_cfg_data[PAGE_W-1:0];
                    tlbrr_pkg::CFG_TEXT_COUNT: r_text_count <= i_cfg_data;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rd_addr    <= '0;
                        r_chk_valid  <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_cnt        <= '0;
                        r_hits       <= '0;
                        unique case (i_func)
                            tlbrr_pkg::FUNC_INSERT: r_state <= S_FIND;
                            tlbrr_pkg::FUNC_INVAL:  r_state <= S_SCAN;
                            tlbrr_pkg::FUNC_SWITCH: begin
                                r_state <= (i_pid == r_last_pid) ? S_FIN : S_SCAN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FIND: begin
                    r_state <= S_FIND2;
                end
                S_FIND2: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_valid[ins_slot] <= 1'b1;
                    if (!find_found) begin
                        r_victim <= (r_victim == IW'(TLB_ENTRIES - 1)) ? '0
                                                                        : r_victim + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_SCAN: begin
                    if (scan_go) begin
                        // Entry whose data has just come out of the memory.
                        if (scan_proc && chk_hit) begin
                            if (r_op == tlbrr_pkg::FUNC_INVAL) begin
                                r_valid[r_chk_idx] <= 1'b0;
                                r_hits             <= r_hits + 1'b1;
                            end else begin
                                r_pend_valid <= 1'b1;
                                r_cnt        <= r_cnt + 1'b1;
                            end
                        end
                        // Next read of the walk.
                        if (issue_more) begin
                            r_chk_valid <= 1'b1;
                            r_rd_addr   <= r_rd_addr + 1'b1;
                        end else begin
                            r_chk_valid <= 1'b0;
                        end
                        if (scan_done) begin
                            if (r_op == tlbrr_pkg::FUNC_SWITCH) begin
                                r_valid    <= '0;
                                r_last_pid <= r_pid;
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= tlbrr_pkg::t_func'(i_func);
            r_page  <= i_page;
            r_frame <= i_frame;
            r_pid   <= i_pid;
            if (i_pid == r_last_pid) begin
                r_res <= '{kind: tlbrr_pkg::KIND_SAME, slot: '0, hits: '0,
                           page: '0, pid: '0, last: 1'b1};
            end
        end

        if (r_state == S_INS) begin
            if (find_found) begin
                r_res <= '{kind: tlbrr_pkg::KIND_FREE, slot: SLOT_W'(ins_slot), hits: '0,
                           page: '0, pid: '0, last: 1'b1};
            end else begin
                r_res <= '{kind: tlbrr_pkg::KIND_REPLACED, slot: SLOT_W'(ins_slot),
                           hits: '0, page: rd_data.page, pid: r_pid, last: 1'b1};
            end
        end

        if (scan_go && issue_more) begin
            r_chk_idx <= r_rd_addr[IW-1:0];
        end

        // A new eviction pushes the one held before it, which is then not last.
        if (scan_proc && chk_hit && (r_op == tlbrr_pkg::FUNC_SWITCH)) begin
            r_pend_slot <= r_chk_idx;
            r_pend_page <= rd_data.page;
            if (r_pend_valid) begin
                r_out <= '{kind: tlbrr_pkg::KIND_EVICT, slot: SLOT_W'(r_pend_slot),
                           hits: '0, page: r_pend_page, pid: r_last_pid, last: 1'b0};
            end
        end

        if (scan_done) begin
            if (r_op == tlbrr_pkg::FUNC_INVAL) begin
                r_res <= '{kind: tlbrr_pkg::KIND_CLEARED, slot: '0, hits: r_hits,
                           page: '0, pid: '0, last: 1'b1};
            end else if (r_pend_valid) begin
                r_res <= '{kind: tlbrr_pkg::KIND_EVICT, slot: SLOT_W'(r_pend_slot),
                           hits: '0, page: r_pend_page, pid: r_last_pid, last: 1'b1};
            end else begin
                r_res <= '{kind: tlbrr_pkg::KIND_EMPTY, slot: '0, hits: '0,
                           page: '0, pid: '0, last: 1'b1};
            end
        end

        if (fin_push) begin
            r_out <= r_res;
        end
    end

    // Ports.
    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_slot         = r_out.slot;
    assign o_hits         = r_out.hits;
    assign o_evicted_page = r_out.page;
    assign o_evicted_pid  = r_out.pid;
    assign o_last         = r_out.last;

    // The free-slot search must point at a slot that is really free.
    `ASSERT_IMPLIES(a_free_slot_invalid, i_clk, i_rst_n, (r_state == S_INS) && find_found, !r_valid[find_idx], "insert chose a slot that is already valid")

    // A finished process switch leaves the whole table invalid.
    `ASSERT_NEXT(a_switch_clears, i_clk, i_rst_n, scan_done && (r_op == tlbrr_pkg::FUNC_SWITCH), r_valid == '0, "process switch left valid entries")

    // No more eviction notices than the result limit.
    `ASSERT_NEVER(a_notice_limit, i_clk, i_rst_n, r_cnt > CNT_W'(MAXRES), "eviction notice count over limit")

endmodule

`default_nettype wire

// ===== test/tlb_mirror_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_mirror_pkg
// Shadow copy of the translation table and the queue of results it predicts.
// Each accepted request updates the copy and queues the results it causes.
// Each returned result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlb_mirror_pkg;

    import tlbrr_pkg::*;

    localparam int         ENTRIES     = 64;
    // The one operation code that the block ignores.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    class tlb_mirror;

        logic [PAGE_W-1:0]  page_mem  [ENTRIES];
        logic [FRAME_W-1:0] frame_mem [ENTRIES];
        bit                 valid_mem [ENTRIES];
        bit                 write_mem [ENTRIES];
        int unsigned        victim_slot;
        logic [PID_W-1:0]   owner_pid;
        logic [PAGE_W-1:0]  text_base;
        logic [COUNT_W-1:0] text_count;

        t_result expected_notices[$];
        int      errors;
        int      requests;
        int      notices;
        int      kind_count[8];

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                clear_slot(i);
            end
            victim_slot = 0;
            owner_pid   = '0;
            text_base   = '0;
            text_count  = '0;
            errors      = 0;
            requests    = 0;
            notices     = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void clear_slot(int i);
            valid_mem[i] = 1'b0;
            write_mem[i] = 1'b0;
            page_mem[i]  = '0;
            frame_mem[i] = '0;
        endfunction

        function void fill_slot(int i, logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame,
                                bit text_ro);
            page_mem[i]  = page;
            frame_mem[i] = frame;
            valid_mem[i] = 1'b1;
            write_mem[i] = !text_ro;
        endfunction

        function void set_register(logic index, logic [COUNT_W-1:0] data);
            if (index == CFG_TEXT_BASE) begin
                text_base = data[PAGE_W-1:0];
            end else begin
                text_count = data;
            end
        endfunction

        // Fields that do not apply to a kind stay zero.
        function t_result notice(t_kind k, int slot_no, int hit_no, logic [PAGE_W-1:0] page,
                                 logic [PID_W-1:0] pid, bit fin);
            t_result r;
            r.kind = k;
            r.slot = slot_no[SLOT_W-1:0];
            r.hits = hit_no[HITS_W-1:0];
            r.page = page;
            r.pid  = pid;
            r.last = fin;
            return r;
        endfunction

        function void note_request(logic [1:0] func, logic [PAGE_W-1:0] page,
                                   logic [FRAME_W-1:0] frame, logic [PID_W-1:0] pid);
            bit      text_ro;
            int      free_slot;
            int      v;
            int      cleared;
            t_result walk[$];
            requests++;
            case (func)
                FUNC_INSERT: begin
                    // The text range end is exclusive; the difference cannot wrap.
                    text_ro = (page >= text_base) &&
                              ({1'b0, page - text_base} < text_count);
                    free_slot = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!valid_mem[i] && free_slot < 0) free_slot = i;
                    end
                    if (free_slot >= 0) begin
                        fill_slot(free_slot, page, frame, text_ro);
                        expected_notices.push_back(notice(KIND_FREE, free_slot, 0, '0, '0, 1'b1));
                    end else begin
                        // Full table: overwrite the round-robin victim.
                        v = victim_slot;
                        expected_notices.push_back(
                            notice(KIND_REPLACED, v, 0, page_mem[v], pid, 1'b1));
                        victim_slot = (v + 1) % ENTRIES;
                        fill_slot(v, page, frame, text_ro);
                    end
                end
                FUNC_INVAL: begin
                    cleared = 0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid_mem[i] && frame_mem[i] == frame) begin
                            clear_slot(i);
                            cleared++;
                        end
                    end
                    expected_notices.push_back(notice(KIND_CLEARED, 0, cleared, '0, '0, 1'b1));
                end
                FUNC_SWITCH: begin
                    if (pid == owner_pid) begin
                        expected_notices.push_back(notice(KIND_SAME, 0, 0, '0, '0, 1'b1));
                    end else begin
                        // Every valid page leaves under the old id; the victim
                        // pointer survives the flush.
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (valid_mem[i] && walk.size() < MAX_RESULTS) begin
                                walk.push_back(
                                    notice(KIND_EVICT, i, 0, page_mem[i], owner_pid, 1'b0));
                            end
                            clear_slot(i);
                        end
                        owner_pid = pid;
                        if (walk.size() == 0) begin
                            walk.push_back(notice(KIND_EMPTY, 0, 0, '0, '0, 1'b1));
                        end else begin
                            walk[walk.size()-1].last = 1'b1;
                        end
                        foreach (walk[j]) expected_notices.push_back(walk[j]);
                    end
                end
                default: begin
                    // The unused code changes nothing.
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: result %0d field %s expected %h actual %h",
                         $time, notices, name, want, got);
                errors++;
            end
        endfunction

        function void check_notice(t_result got);
            t_result want;
            if (expected_notices.size() == 0) begin
                $display("%0t: unexpected result kind %0d slot %0d page %h expected none",
                         $time, got.kind, got.slot, got.page);
                errors++;
                return;
            end
            want = expected_notices.pop_front();
            notices++;
            kind_count[got.kind]++;
            check_field("kind", want.kind, got.kind);
            check_field("slot", want.slot, got.slot);
            check_field("hits", want.hits, got.hits);
            check_field("evicted_page", want.page, got.page);
            check_field("evicted_pid", want.pid, got.pid);
            check_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

// ===== test/tlb_refill_round_robin_core_tb.sv =====
// ----------------------------------------------------------------------------
// tlb_refill_round_robin_core_tb
// Drives inserts, frame invalidates and process switches into the table with
// random idling on both channels, and checks every result against a shadow
// table kept by the scoreboard. The text range is reprogrammed between
// bursts, including its extreme settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlb_refill_round_robin_core_tb;

    import tlbrr_pkg::*;
    import tlb_mirror_pkg::*;

    localparam int    ITEM_TARGET  = 500;
    localparam int    DRAIN_TAIL   = 80;
    localparam longint RUN_LIMIT_NS = 100_000_000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func      = '0;
    logic [19:0] i_page      = '0;
    logic [19:0] i_frame     = '0;
    logic [15:0] i_pid       = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [2:0]  o_kind;
    logic [5:0]  o_slot;
    logic [6:0]  o_hits;
    logic [19:0] o_evicted_page;
    logic [15:0] o_evicted_pid;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [20:0] i_cfg_data  = '0;

    tlb_mirror   mirror;
    t_result     seen;
    int          rx_wait = 0;
    bit          calm    = 1'b0;
    int          sent    = 0;
    logic [15:0] run_pid = '0;

    tlb_refill_round_robin_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_page         (i_page),
        .i_frame        (i_frame),
        .i_pid          (i_pid),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_slot         (o_slot),
        .o_hits         (o_hits),
        .o_evicted_page (o_evicted_page),
        .o_evicted_pid  (o_evicted_pid),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none at all in calm stretches.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls on ready.
    always @(posedge i_clk) begin
        if (rx_wait > 0) begin
            rx_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            rx_wait = pick_gap();
        end
    end

    // Every result taken is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.kind = t_kind'(o_kind);
            seen.slot = o_slot;
            seen.hits = o_hits;
            seen.page = o_evicted_page;
            seen.pid  = o_evicted_pid;
            seen.last = o_last;
            mirror.check_notice(seen);
        end
    end

    task automatic pause(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // One request; valid stays high into the next request when no gap follows.
    task automatic send_request(logic [1:0] func, logic [19:0] page, logic [19:0] frame,
                                logic [15:0] pid);
        i_valid <= 1'b1;
        i_func  <= func;
        i_page  <= page;
        i_frame <= frame;
        i_pid   <= pid;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        mirror.note_request(func, page, frame, pid);
        if (func == FUNC_SWITCH) run_pid = pid;
        if (func != FUNC_UNUSED) sent++;
        pause(pick_gap());
    endtask

    // Hold off until every predicted result is back and any walk has ended.
    task automatic settle();
        i_valid <= 1'b0;
        while (mirror.expected_notices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Both registers in back-to-back writes, valid held across them.
    task automatic write_text_range(logic [19:0] base, logic [20:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TEXT_BASE;
        i_cfg_data  <= {1'b0, base};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mirror.set_register(CFG_TEXT_BASE, {1'b0, base});
        i_cfg_index <= CFG_TEXT_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mirror.set_register(CFG_TEXT_COUNT, count);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(int k);
        case (k % 6)
            0: write_text_range(20'h00100, 21'h000010);
            1: write_text_range(20'h00000, 21'h000000);
            2: write_text_range(20'h00000, 21'h100000);
            3: write_text_range(20'hFFFFF, 21'h100000);
            4: write_text_range(20'hFFFFF, 21'h000001);
            default: write_text_range(20'($urandom), 21'($urandom_range(0, 21'h100000)));
        endcase
    endtask

    // Pages on and around the edges of the text range, or anywhere.
    function automatic logic [19:0] pick_page();
        logic [19:0] base;
        logic [20:0] span;
        base = mirror.text_base;
        span = mirror.text_count;
        case ($urandom_range(0, 5))
            0: return base - 20'd1;
            1: return base;
            2: return base + span[19:0] - 20'd1;
            3: return base + span[19:0];
            4: return base + 20'($urandom_range(0, span));
            default: return 20'($urandom);
        endcase
    endfunction

    // A small pool of frames makes invalidates hit several slots.
    function automatic logic [19:0] pick_frame();
        if ($urandom_range(0, 99) < 70) return 20'($urandom_range(0, 15));
        return 20'($urandom);
    endfunction

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int round;
        int burst;
        int pick;
        mirror = new();
        round  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-table cases, field extremes, text range edges,
        // invalidate with and without hits, all kinds of switch.
        write_text_range(20'h00100, 21'h000010);
        send_request(FUNC_SWITCH, 20'h00000, 20'h00000, 16'h0000);
        send_request(FUNC_INVAL,  20'hFFFFF, 20'h00000, 16'h0000);
        send_request(FUNC_SWITCH, 20'h00000, 20'h00000, 16'hFFFF);
        send_request(FUNC_INSERT, 20'h00000, 20'h00000, 16'hFFFF);
        send_request(FUNC_INSERT, 20'hFFFFF, 20'hFFFFF, 16'h0000);
        send_request(FUNC_INSERT, 20'h000FF, 20'h00005, 16'hFFFF);
        send_request(FUNC_INSERT, 20'h00100, 20'h00005, 16'hFFFF);
        send_request(FUNC_INSERT, 20'h0010F, 20'h00005, 16'hFFFF);
        send_request(FUNC_INSERT, 20'h00110, 20'hFFFFF, 16'hFFFF);
        send_request(FUNC_UNUSED, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_request(FUNC_INVAL,  20'h00000, 20'h00005, 16'hFFFF);
        send_request(FUNC_INSERT, 20'h12345, 20'h00007, 16'h5A5A);
        send_request(FUNC_INVAL,  20'h00000, 20'hFFFFF, 16'h0000);
        send_request(FUNC_INVAL,  20'h00000, 20'h00000, 16'h0000);
        send_request(FUNC_SWITCH, 20'h00000, 20'h00000, 16'h1234);
        send_request(FUNC_SWITCH, 20'h00000, 20'h00000, 16'h1234);
        send_request(FUNC_SWITCH, 20'h00000, 20'h00000, 16'h0000);

        // Random bursts: mostly inserts, so the table fills and the victim
        // pointer wraps, each burst closed by a process switch.
        while (sent < ITEM_TARGET) begin
            round++;
            if (round % 2 == 0) begin
                settle();
                apply_setting(round / 2);
            end
            calm  = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(30, 110);
            // Keep the total close to the target.
            if (burst > ITEM_TARGET - sent) burst = ITEM_TARGET - sent;
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    send_request(FUNC_INSERT, pick_page(), pick_frame(), 16'($urandom));
                end else if (pick < 91) begin
                    send_request(FUNC_INVAL, 20'($urandom), pick_frame(), 16'($urandom));
                end else if (pick < 95) begin
                    send_request(FUNC_UNUSED, 20'($urandom), 20'($urandom), 16'($urandom));
                end else begin
                    send_request(FUNC_SWITCH, 20'($urandom), 20'($urandom),
                                 $urandom_range(0, 1) ? run_pid : 16'($urandom));
                end
            end
            send_request(FUNC_SWITCH, 20'($urandom), 20'($urandom),
                         ($urandom_range(0, 4) == 0) ? run_pid : 16'($urandom));
        end

        calm = 1'b0;
        settle();
        $display("Covered %0d requests in %0d bursts and %0d checked results.",
                 mirror.requests, round, mirror.notices);
        $display("Kinds seen: free %0d, replaced %0d, cleared %0d, evicted %0d, empty %0d, same %0d.",
                 mirror.kind_count[KIND_FREE], mirror.kind_count[KIND_REPLACED],
                 mirror.kind_count[KIND_CLEARED], mirror.kind_count[KIND_EVICT],
                 mirror.kind_count[KIND_EMPTY], mirror.kind_count[KIND_SAME]);
        if (mirror.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tlbrr_pkg.sv
rtl/tlbrr_ram.sv
rtl/tlbrr_free_find.sv
rtl/tlb_refill_round_robin_core.sv
test/tlb_mirror_pkg.sv
test/tlb_refill_round_robin_core_tb.sv
